// File: sv/assert_macros.svh
// Assertion macros used by the checker file of this project.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define BB_ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define BB_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: sv/bb3ea_pkg.sv
package bb3ea_pkg;

    localparam int MAX_WIDTH_DEF = 4096;

    localparam int CH_BITS      = 8;
    localparam int NUM_CH       = 3;
    localparam int PIX_BITS     = CH_BITS * NUM_CH;
    localparam int DIM_BITS     = 13;
    localparam int TOT_BITS     = 2 * DIM_BITS;
    localparam int POS_BITS     = TOT_BITS + 1;
    localparam int SUM_BITS     = 12;
    localparam int CNT_BITS     = 4;
    localparam int RCP_SHIFT    = 16;
    localparam int RCP_BITS     = RCP_SHIFT + 1;
    localparam int PROD_BITS    = SUM_BITS + RCP_BITS;
    localparam int CH_IDX_BITS  = 2;
    localparam int CFG_IDX_BITS = 2;

    localparam logic [CH_IDX_BITS-1:0] LAST_CH = CH_IDX_BITS'(NUM_CH - 1);

    // Configuration register indexes.
    localparam logic [CFG_IDX_BITS-1:0] CFG_FRAME_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_FRAME_HEIGHT = 2'd1;

    localparam logic [DIM_BITS-1:0] DEF_FRAME_WIDTH  = 13'd640;
    localparam logic [DIM_BITS-1:0] DEF_FRAME_HEIGHT = 13'd480;

    typedef struct packed {
        logic                   accept;
        logic                   shift;
        logic                   sum;
        logic                   mul;
        logic                   store;
        logic                   load;
        logic [CH_IDX_BITS-1:0] ch;
    } t_cmd;

    typedef struct packed {
        logic ignore;
        logic has_result;
        logic out_free;
    } t_status;

    // Reciprocal ceil(2^16 / count); exact floor division for every sum a
    // window of that many 8-bit pixels can produce.
    function automatic logic [RCP_BITS-1:0] div_recip(input logic [CNT_BITS-1:0] cnt);
        logic [RCP_BITS-1:0] m;
        case (cnt)
            4'd1:    m = 17'd65536;
            4'd2:    m = 17'd32768;
            4'd3:    m = 17'd21846;
            4'd4:    m = 17'd16384;
            4'd6:    m = 17'd10923;
            4'd9:    m = 17'd7282;
            default: m = 17'd65536;
        endcase
        return m;
    endfunction

endpackage

// File: sv/bb3ea_in_if.sv
interface bb3ea_in_if;
    logic                             valid;
    logic                             ready;
    logic [bb3ea_pkg::CH_BITS-1:0]    red;
    logic [bb3ea_pkg::CH_BITS-1:0]    green;
    logic [bb3ea_pkg::CH_BITS-1:0]    blue;
    logic                             flush;

    modport source (output valid, output red, output green, output blue, output flush,
                    input ready);
    modport sink   (input valid, input red, input green, input blue, input flush,
                    output ready);
endinterface

// File: sv/bb3ea_out_if.sv
interface bb3ea_out_if;
    logic                             valid;
    logic                             ready;
    logic [bb3ea_pkg::CH_BITS-1:0]    out_red;
    logic [bb3ea_pkg::CH_BITS-1:0]    out_green;
    logic [bb3ea_pkg::CH_BITS-1:0]    out_blue;
    logic                             frame_last;

    modport source (output valid, output out_red, output out_green, output out_blue,
                    output frame_last, input ready);
    modport sink   (input valid, input out_red, input out_green, input out_blue,
                    input frame_last, output ready);
endinterface

// File: sv/bb3ea_ctrl.sv
module bb3ea_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  bb3ea_pkg::t_status i_status,
    output bb3ea_pkg::t_cmd    o_cmd
);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_SHIFT = 3'd1;
    localparam logic [2:0] S_SUM   = 3'd2;
    localparam logic [2:0] S_MUL   = 3'd3;
    localparam logic [2:0] S_STORE = 3'd4;
    localparam logic [2:0] S_OUT   = 3'd5;

    logic [2:0]                        r_state;
    logic [2:0]                        n_state;
    logic [bb3ea_pkg::CH_IDX_BITS-1:0] r_ch;
    logic [bb3ea_pkg::CH_IDX_BITS-1:0] n_ch;

    always_comb begin
        n_state    = r_state;
        n_ch       = r_ch;
        o_cmd      = '0;
        o_cmd.ch   = r_ch;
        o_in_ready = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_in_ready   = 1'b1;
                o_cmd.accept = i_in_valid;
                if (i_in_valid) begin
                    n_state = S_SHIFT;
                end
            end
            S_SHIFT: begin
                o_cmd.shift = 1'b1;
                if (i_status.ignore || !i_status.has_result) begin
                    n_state = S_IDLE;
                end else begin
                    n_state = S_SUM;
                end
            end
            S_SUM: begin
                o_cmd.sum = 1'b1;
                n_ch      = '0;
                n_state   = S_MUL;
            end
            S_MUL: begin
                o_cmd.mul = 1'b1;
                n_state   = S_STORE;
            end
            S_STORE: begin
                o_cmd.store = 1'b1;
                if (r_ch == bb3ea_pkg::LAST_CH) begin
                    n_state = S_OUT;
                end else begin
                    n_ch    = r_ch + 1'b1;
                    n_state = S_MUL;
                end
            end
            S_OUT: begin
                if (i_status.out_free) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_ch    <= '0;
        end else begin
            r_state <= n_state;
            r_ch    <= n_ch;
        end
    end

endmodule

// File: sv/bb3ea_dpath.sv
module bb3ea_dpath #(
    parameter int MAX_WIDTH = bb3ea_pkg::MAX_WIDTH_DEF
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_cfg_we,
    input  logic [bb3ea_pkg::CFG_IDX_BITS-1:0]   i_cfg_idx,
    input  logic [bb3ea_pkg::DIM_BITS-1:0]       i_cfg_data,
    input  logic [bb3ea_pkg::CH_BITS-1:0]        i_red,
    input  logic [bb3ea_pkg::CH_BITS-1:0]        i_green,
    input  logic [bb3ea_pkg::CH_BITS-1:0]        i_blue,
    input  logic                                 i_flush,
    input  bb3ea_pkg::t_cmd                      i_cmd,
    output bb3ea_pkg::t_status                   o_status,
    output logic                                 o_out_valid,
    input  logic                                 i_out_ready,
    output logic [bb3ea_pkg::CH_BITS-1:0]        o_out_red,
    output logic [bb3ea_pkg::CH_BITS-1:0]        o_out_green,
    output logic [bb3ea_pkg::CH_BITS-1:0]        o_out_blue,
    output logic                                 o_frame_last
);

    localparam int DB  = bb3ea_pkg::DIM_BITS;
    localparam int DW1 = bb3ea_pkg::DIM_BITS + 1;
    localparam int PB  = bb3ea_pkg::PIX_BITS;
    localparam int CB  = bb3ea_pkg::CH_BITS;
    localparam int NC  = bb3ea_pkg::NUM_CH;
    localparam int SB  = bb3ea_pkg::SUM_BITS;
    localparam int QB  = bb3ea_pkg::POS_BITS;
    localparam int TB  = bb3ea_pkg::TOT_BITS;
    localparam int AW  = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam logic [DW1-1:0] MW = DW1'(MAX_WIDTH);

    // Configuration and frame geometry.
    logic [DB-1:0]  r_frame_width;
    logic [DB-1:0]  r_frame_height;
    logic [TB-1:0]  r_total;
    logic [DB-1:0]  eff_w;
    logic [DB-1:0]  eff_h;
    logic           cfg_hit;

    // Input capture and line stores: upper row in the high half, middle row in the low.
    logic [PB-1:0]   r_pix;
    logic            r_flush;
    logic [2*PB-1:0] r_rd;
    logic [2*PB-1:0] line_mem [MAX_WIDTH];
    logic [PB-1:0]   r_win [3][3];
    logic [PB-1:0]   pix;
    logic            in_frame;
    logic            do_shift;

    // Stream position counters.
    logic [AW-1:0]  r_in_col;
    logic [QB-1:0]  r_in_pos;
    logic [QB-1:0]  r_emitted;
    logic [DB-1:0]  r_ctr_col;
    logic [DB-1:0]  r_ctr_row;
    logic           frame_end;

    // Averaging.
    logic [2:0]                          col_ok;
    logic [2:0]                          row_ok;
    logic [1:0]                          ncols;
    logic [1:0]                          nrows;
    logic [bb3ea_pkg::CNT_BITS-1:0]      n_cnt;
    logic [bb3ea_pkg::CNT_BITS-1:0]      r_cnt;
    logic [SB-1:0]                       n_sum [NC];
    logic [SB-1:0]                       r_sum [NC];
    logic [bb3ea_pkg::PROD_BITS-1:0]     r_prod;
    logic [CB-1:0]                       r_quot [NC];
    logic                                r_out_valid;

    assign eff_w = (r_frame_width == '0) ? DB'(1) :
                   ({1'b0, r_frame_width} > MW) ? MW[DB-1:0] : r_frame_width;
    assign eff_h = (r_frame_height == '0) ? DB'(1) : r_frame_height;

    assign cfg_hit = i_cfg_we && (i_cfg_idx == bb3ea_pkg::CFG_FRAME_WIDTH ||
                                  i_cfg_idx == bb3ea_pkg::CFG_FRAME_HEIGHT);

    assign in_frame = r_in_pos < QB'(r_total);
    assign pix      = in_frame ? r_pix : '0;
    assign do_shift = i_cmd.shift && !o_status.ignore;
    assign frame_end = (r_emitted + 1'b1) >= QB'(r_total);

    assign o_status.ignore     = r_flush && in_frame;
    assign o_status.has_result = r_in_pos >= (QB'(eff_w) + 1'b1);
    assign o_status.out_free   = !r_out_valid || i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_width  <= bb3ea_pkg::DEF_FRAME_WIDTH;
            r_frame_height <= bb3ea_pkg::DEF_FRAME_HEIGHT;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                bb3ea_pkg::CFG_FRAME_WIDTH:  r_frame_width  <= i_cfg_data;
                bb3ea_pkg::CFG_FRAME_HEIGHT: r_frame_height <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    // The frame size product is registered from the configuration registers; it is
    // first read in the cycle after an item is taken.
    always_ff @(posedge i_clk) begin
        r_total <= TB'(eff_w) * TB'(eff_h);
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_pix   <= {i_blue, i_green, i_red};
            r_flush <= i_flush;
            r_rd    <= line_mem[r_in_col];
        end
        if (do_shift) begin
            line_mem[r_in_col] <= {r_rd[PB-1:0], pix};
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_shift) begin
            r_win[0] <= r_win[1];
            r_win[1] <= r_win[2];
            r_win[2][0] <= r_rd[2*PB-1:PB];
            r_win[2][1] <= r_rd[PB-1:0];
            r_win[2][2] <= pix;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || cfg_hit) begin
            r_in_col  <= '0;
            r_in_pos  <= '0;
            r_emitted <= '0;
            r_ctr_col <= '0;
            r_ctr_row <= '0;
        end else if (do_shift) begin
            r_in_pos <= r_in_pos + 1'b1;
            if ((DW1'(r_in_col) + 1'b1) >= DW1'(eff_w)) begin
                r_in_col <= '0;
            end else begin
                r_in_col <= r_in_col + 1'b1;
            end
        end else if (i_cmd.load) begin
            if (frame_end) begin
                r_in_col  <= '0;
                r_in_pos  <= '0;
                r_emitted <= '0;
                r_ctr_col <= '0;
                r_ctr_row <= '0;
            end else begin
                r_emitted <= r_emitted + 1'b1;
                if ((DW1'(r_ctr_col) + 1'b1) >= DW1'(eff_w)) begin
                    r_ctr_col <= '0;
                    r_ctr_row <= r_ctr_row + 1'b1;
                end else begin
                    r_ctr_col <= r_ctr_col + 1'b1;
                end
            end
        end
    end

    // Neighbors that fall outside the image are masked out of the sums.
    always_comb begin
        col_ok[0] = r_ctr_col != '0;
        col_ok[1] = 1'b1;
        col_ok[2] = (DW1'(r_ctr_col) + 1'b1) < DW1'(eff_w);
        row_ok[0] = r_ctr_row != '0;
        row_ok[1] = 1'b1;
        row_ok[2] = (DW1'(r_ctr_row) + 1'b1) < DW1'(eff_h);
        ncols = {1'b0, col_ok[0]} + 2'd1 + {1'b0, col_ok[2]};
        nrows = {1'b0, row_ok[0]} + 2'd1 + {1'b0, row_ok[2]};
        n_cnt = bb3ea_pkg::CNT_BITS'(ncols) * bb3ea_pkg::CNT_BITS'(nrows);
        for (int ch = 0; ch < NC; ch++) begin
            n_sum[ch] = '0;
            for (int c = 0; c < 3; c++) begin
                for (int r = 0; r < 3; r++) begin
                    if (col_ok[c] && row_ok[r]) begin
                        n_sum[ch] = n_sum[ch] + SB'(r_win[c][r][ch*CB +: CB]);
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.sum) begin
            r_sum <= n_sum;
            r_cnt <= n_cnt;
        end
        if (i_cmd.mul) begin
            r_prod <= bb3ea_pkg::PROD_BITS'(r_sum[i_cmd.ch]) *
                      bb3ea_pkg::PROD_BITS'(bb3ea_pkg::div_recip(r_cnt));
        end
        if (i_cmd.store) begin
            r_quot[i_cmd.ch] <= r_prod[bb3ea_pkg::RCP_SHIFT +: CB];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            o_out_red    <= r_quot[0];
            o_out_green  <= r_quot[1];
            o_out_blue   <= r_quot[2];
            o_frame_last <= frame_end;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_out_valid = r_out_valid;

endmodule

// File: sv/box_blur_3x3_edge_average.sv
// 3x3 box blur over an RGB pixel stream in raster order. Each channel of a
// result is the truncated average of the centre pixel's neighbors that lie
// inside the image (nine inside, six on an edge, four in a corner, fewer for
// images one pixel wide or high). The result for raster position p leaves
// after the item for position p+width+1 is taken; items with flush set stand
// in for positions past the frame end and drain the last width+1 results,
// while a flush inside the frame is consumed without effect. frame_last marks
// the final result of a frame, after which the next item starts a new frame.
// Width 0 acts as 1 and widths above MAX_WIDTH act as MAX_WIDTH; height 0
// acts as 1. A write to either register drops the current frame and is to be
// made only while no result is outstanding. The block works on one item at a
// time: an item with no result goes through capture with line store read,
// then store write and window shift; one with a result also has its sums
// registered, and its three channel quotients go one after another through a
// single reciprocal multiplier, each multiplied then stored. A result
// waiting in the output register does not stop the next item from being
// taken; the block only stalls once a newer result is ready to be loaded.
// The line stores hold no reset state and need no clearing after reset.
module box_blur_3x3_edge_average #(
    parameter int MAX_WIDTH = bb3ea_pkg::MAX_WIDTH_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [bb3ea_pkg::CFG_IDX_BITS-1:0]  i_cfg_idx,
    input  logic [bb3ea_pkg::DIM_BITS-1:0]      i_cfg_data,
    bb3ea_in_if.sink                            i_pix,
    bb3ea_out_if.source                         o_res
);

    // Commands flow from the controller to the datapath; status flows back.
    bb3ea_pkg::t_cmd    cmd;
    bb3ea_pkg::t_status status;

    bb3ea_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_pix.valid),
        .o_in_ready (i_pix.ready),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    // The datapath owns the configuration registers, line stores, window,
    // position counters, the averaging unit and the output register.
    bb3ea_dpath #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_dpath (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_idx    (i_cfg_idx),
        .i_cfg_data   (i_cfg_data),
        .i_red        (i_pix.red),
        .i_green      (i_pix.green),
        .i_blue       (i_pix.blue),
        .i_flush      (i_pix.flush),
        .i_cmd        (cmd),
        .o_status     (status),
        .o_out_valid  (o_res.valid),
        .i_out_ready  (o_res.ready),
        .o_out_red    (o_res.out_red),
        .o_out_green  (o_res.out_green),
        .o_out_blue   (o_res.out_blue),
        .o_frame_last (o_res.frame_last)
    );

endmodule

// File: sv/bb3ea_chk.sv
`include "assert_macros.svh"

module bb3ea_chk (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          i_in_valid,
    input logic                          i_in_ready,
    input logic                          i_out_valid,
    input logic                          i_out_ready,
    input logic [bb3ea_pkg::CH_BITS-1:0] i_out_red,
    input logic [bb3ea_pkg::CH_BITS-1:0] i_out_green,
    input logic [bb3ea_pkg::CH_BITS-1:0] i_out_blue,
    input logic                          i_frame_last
);

    logic in_take;
    logic out_stall;

    assign in_take   = i_in_valid && i_in_ready;
    assign out_stall = i_out_valid && !i_out_ready;

    // A stalled result keeps its payload.
    `BB_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, out_stall, $stable({i_out_red, i_out_green, i_out_blue, i_frame_last}) && i_out_valid, "stalled result changed")

    // One item at a time: ready drops right after an item is taken.
    `BB_ASSERT_NEXT(a_one_item, i_clk, i_rst_n, in_take, !i_in_ready, "item taken while busy")

    // A result is formed only after the sum, multiply and store steps, so it never appears right after a take.
    `BB_ASSERT_NEXT(a_no_early_res, i_clk, i_rst_n, in_take, !$rose(i_out_valid), "result too early")

    // A new result is loaded only while no item is being offered space.
    `BB_ASSERT_SAME(a_load_busy, i_clk, i_rst_n, $rose(i_out_valid), $past(!i_in_ready), "result loaded while idle")

endmodule

bind box_blur_3x3_edge_average bb3ea_chk u_bb3ea_chk (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_in_valid   (i_pix.valid),
    .i_in_ready   (i_pix.ready),
    .i_out_valid  (o_res.valid),
    .i_out_ready  (o_res.ready),
    .i_out_red    (o_res.out_red),
    .i_out_green  (o_res.out_green),
    .i_out_blue   (o_res.out_blue),
    .i_frame_last (o_res.frame_last)
);
